// ===== rtl/vsa_pkg.sv =====
package vsa_pkg;

    // Register file geometry. Register indices in an instruction are five bits
    // wide, so no more than 32 registers can ever be named.
    localparam int NUM_REGS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int REG_IDX_W = 5;
    localparam int SWZ_W     = 11;
    localparam int RF_DEPTH  = (NUM_REGS < (1 << REG_IDX_W)) ? NUM_REGS : (1 << REG_IDX_W);
    localparam int RF_AW     = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;

    // Configuration register index (byte address bit 2).
    localparam logic CFG_IDX_OUTPUT = 1'b0;

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_DEF   = 4'd1,
        FN_DP3   = 4'd2,
        FN_FRC   = 4'd3,
        FN_MAD   = 4'd4,
        FN_MAX   = 4'd5,
        FN_MOV   = 4'd6,
        FN_MUL   = 4'd7,
        FN_CLEAR = 4'd8
    } func_t;

    typedef logic signed [31:0] lane_t;
    typedef lane_t [3:0] vec_t;

    // One instruction beat; the last field, func, sits in the lowest bits.
    typedef struct packed {
        logic [3:0]           pad;
        logic [63:0]          imm_zw;
        logic [63:0]          imm_xy;
        logic [SWZ_W-1:0]     src2_swz;
        logic [REG_IDX_W-1:0] src2_reg;
        logic [SWZ_W-1:0]     src1_swz;
        logic [REG_IDX_W-1:0] src1_reg;
        logic [SWZ_W-1:0]     src0_swz;
        logic [REG_IDX_W-1:0] src0_reg;
        logic [SWZ_W-1:0]     dst_swz;
        logic [REG_IDX_W-1:0] dst_reg;
        logic [3:0]           func;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] slot_count;
        lane_t       out_w;
        lane_t       out_z;
        lane_t       out_y;
        lane_t       out_x;
    } out_beat_t;

    // Register file write produced by one instruction.
    typedef struct packed {
        logic [3:0] en;
        vec_t       data;
    } wr_t;

endpackage

// ===== rtl/vsa_exec.sv =====
module vsa_exec (
    input  vsa_pkg::in_beat_t ins,
    input  vsa_pkg::vec_t     src_a,
    input  vsa_pkg::vec_t     src_b,
    input  vsa_pkg::vec_t     src_c,
    output vsa_pkg::wr_t      wr,
    output logic [1:0]        slots,
    output logic              clr
);

    localparam int F = vsa_pkg::FRAC_BITS;
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic vsa_pkg::lane_t sat32(input logic signed [65:0] v);
        vsa_pkg::lane_t r;
        if (v > SAT_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_LO)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Lane counts above four behave as four; a count of zero takes the whole register.
    function automatic logic [2:0] swz_count(input logic [vsa_pkg::SWZ_W-1:0] swz);
        logic [2:0] c;
        c = (swz[2:0] > 3'd4) ? 3'd4 : swz[2:0];
        return c;
    endfunction

    function automatic vsa_pkg::vec_t swizzle(input vsa_pkg::vec_t whole,
                                              input logic [vsa_pkg::SWZ_W-1:0] swz);
        vsa_pkg::vec_t v;
        logic [2:0]    cnt;
        cnt = swz_count(swz);
        for (int i = 0; i < 4; i++)
        begin
            if (cnt == 3'd0)
                v[i] = whole[i];
            else if (3'(i) < cnt)
                v[i] = whole[swz[3 + 2 * i +: 2]];
            else
                v[i] = '0;
        end
        return v;
    endfunction

    vsa_pkg::vec_t            a, b, c, r;
    logic signed [63:0]       prod [4];
    logic signed [63:0]       prod_sh [4];
    logic signed [65:0]       dot;
    logic [2:0]               dcnt;

    assign a = swizzle(src_a, ins.src0_swz);
    assign b = swizzle(src_b, ins.src1_swz);
    assign c = swizzle(src_c, ins.src2_swz);

    // One multiplier per lane, shared by mul, mad and dp3.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod[i]    = 64'(a[i]) * 64'(b[i]);
            prod_sh[i] = prod[i] >>> F;
        end
    end

    // Flooring the exact sum equals summing the floors plus the carried fractions.
    assign dot = (66'(prod[0]) + 66'(prod[1]) + 66'(prod[2])) >>> F;

    always_comb
    begin
        r = '0;
        for (int i = 0; i < 4; i++)
        begin
            case (ins.func)
                vsa_pkg::FN_ADD: r[i] = sat32(66'(a[i]) + 66'(b[i]));
                vsa_pkg::FN_DP3: r[i] = sat32(dot);
                vsa_pkg::FN_FRC: r[i] = 32'({{(32 - F){1'b0}}, a[i][F-1:0]});
                vsa_pkg::FN_MAD: r[i] = sat32(66'(prod_sh[i]) + 66'(c[i]));
                vsa_pkg::FN_MAX: r[i] = (a[i] > b[i]) ? a[i] : b[i];
                vsa_pkg::FN_MOV: r[i] = a[i];
                vsa_pkg::FN_MUL: r[i] = sat32(66'(prod_sh[i]));
                default:         r[i] = '0;
            endcase
        end
    end

    assign dcnt = swz_count(ins.dst_swz);

    // Destination mask: positions are written in order, so the highest
    // position naming a lane wins.
    always_comb
    begin
        wr    = '0;
        slots = 2'd1;
        clr   = 1'b0;
        case (ins.func)
            vsa_pkg::FN_ADD, vsa_pkg::FN_DP3, vsa_pkg::FN_FRC, vsa_pkg::FN_MAD,
            vsa_pkg::FN_MAX, vsa_pkg::FN_MOV, vsa_pkg::FN_MUL:
            begin
                if (ins.func == vsa_pkg::FN_MAD)
                    slots = 2'd2;
                if (dcnt == 3'd0)
                begin
                    wr.en   = 4'hF;
                    wr.data = r;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < dcnt)
                        begin
                            wr.en[ins.dst_swz[3 + 2 * i +: 2]]   = 1'b1;
                            wr.data[ins.dst_swz[3 + 2 * i +: 2]] = r[i];
                        end
                    end
                end
            end
            vsa_pkg::FN_DEF:
            begin
                slots   = 2'd0;
                wr.en   = 4'hF;
                wr.data = {ins.imm_zw[63:32], ins.imm_zw[31:0],
                           ins.imm_xy[63:32], ins.imm_xy[31:0]};
            end
            vsa_pkg::FN_CLEAR:
            begin
                slots = 2'd0;
                clr   = 1'b1;
            end
            default:
            begin
                slots = 2'd0;
            end
        endcase
    end

endmodule

// ===== rtl/vec4_shader_alu_top.sv =====
// Four-lane Q16.16 shader ALU. Each input beat carries one pre-decoded
// instruction (add, def, dp3, frc, mad, max, mov, mul or clear); each accepted
// beat produces exactly one output beat holding the four lanes of the register
// selected by output_reg, as they stand after that instruction, and the
// saturating issue-slot count. The block accepts a beat every cycle while
// the result output is not stalled: an instruction is held in the execute
// stage and its result is loaded into the output register as it leaves that
// stage, and the result beat is offered from the output register. A
// following instruction may read a register written by the one just before
// it without any bubble. The register file reads are set off at the moment a
// beat is accepted, and the write of the instruction in the execute stage is
// forwarded into them. Reset and the clear instruction empty the register
// file by clearing its per-lane valid bits, so no clearing pass is needed.
// output_reg (byte address 0 on the APB port) must only be written while no
// instruction is in flight.
module vec4_shader_alu_top (
    input  logic         clk,
    input  logic         rst_n,
    // Instruction beats. tdata from bit 0 up: func, dst_reg, dst_swz,
    // src0_reg, src0_swz, src1_reg, src1_swz, src2_reg, src2_swz,
    // imm_xy, imm_zw, then four zero bits.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,
    // Result beats. tdata from bit 0 up: out_x, out_y, out_z, out_w, slot_count.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = vsa_pkg::RF_AW;
    localparam int DEPTH = vsa_pkg::RF_DEPTH;
    // Four read ports: three sources and the reported register.
    localparam int NPORT = 4;
    localparam int OUT_PORT = 3;

    vsa_pkg::in_beat_t  beat_in;
    vsa_pkg::in_beat_t  ins_reg;
    vsa_pkg::out_beat_t out_reg;
    vsa_pkg::wr_t       wr_raw;
    vsa_pkg::wr_t       wr;
    vsa_pkg::vec_t      src_whole [NPORT];
    vsa_pkg::vec_t      rd_data [NPORT];
    vsa_pkg::vec_t      byp_reg;
    vsa_pkg::vec_t      out_lanes;

    logic                         s1_v_reg;
    logic                         out_v_reg;
    logic                         s_fire;
    logic                         s1_adv;
    logic                         s1_fire;
    logic [1:0]                   slots;
    logic                         clr;
    logic                         dst_ok;
    logic [AW-1:0]                dst_addr;
    logic [vsa_pkg::REG_IDX_W-1:0] output_reg_reg;
    logic [15:0]                  slot_reg;
    logic [15:0]                  slot_next;
    logic [16:0]                  slot_sum;
    logic [3:0]                   valid_reg [DEPTH];
    logic [3:0]                   valid_next [DEPTH];
    logic [vsa_pkg::REG_IDX_W-1:0] rd_idx [NPORT];
    logic [AW-1:0]                rd_addr [NPORT];
    logic [NPORT-1:0]             rd_ok;
    logic [3:0]                   srcv_reg [NPORT];
    logic [3:0]                   hit_reg [NPORT];

    assign beat_in = vsa_pkg::in_beat_t'(s_tdata);

    // ------------------------------------------------------------------
    // Handshake: the execute stage moves on whenever the output register
    // is empty or is being emptied in this cycle.
    // ------------------------------------------------------------------
    assign s1_adv   = !out_v_reg || m_tready;
    assign s1_fire  = s1_v_reg && s1_adv;
    assign s_tready = !s1_v_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                s1_v_reg <= 1'b1;
            else if (s1_fire)
                s1_v_reg <= 1'b0;

            if (s1_fire)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port: one register, written on the access cycle.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == vsa_pkg::CFG_IDX_OUTPUT) ? 32'(output_reg_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            output_reg_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr[2] == vsa_pkg::CFG_IDX_OUTPUT)
            output_reg_reg <= pwdata[vsa_pkg::REG_IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Execute stage.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_fire)
            ins_reg <= beat_in;
    end

    vsa_exec u_exec (
        .ins   (ins_reg),
        .src_a (src_whole[0]),
        .src_b (src_whole[1]),
        .src_c (src_whole[2]),
        .wr    (wr_raw),
        .slots (slots),
        .clr   (clr)
    );

    // Writes to a register beyond the file are dropped.
    assign dst_ok   = {1'b0, ins_reg.dst_reg} < 6'(DEPTH);
    assign dst_addr = AW'(ins_reg.dst_reg);
    assign wr.en    = wr_raw.en & {4{dst_ok}};
    assign wr.data  = wr_raw.data;

    // Per-lane valid bits stand in for the reset value of the register file:
    // a lane never written since reset or the last clear reads as zero.
    always_comb
    begin
        for (int r = 0; r < DEPTH; r++)
        begin
            valid_next[r] = valid_reg[r];
            if (s1_fire)
            begin
                if (clr)
                    valid_next[r] = '0;
                else if (dst_addr == AW'(r))
                    valid_next[r] = valid_reg[r] | wr.en;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < DEPTH; r++)
                valid_reg[r] <= '0;
        end
        else
        begin
            for (int r = 0; r < DEPTH; r++)
                valid_reg[r] <= valid_next[r];
        end
    end

    // ------------------------------------------------------------------
    // Register file: one copy per read port, each banked by lane so that a
    // masked write touches only its lanes. Reads are launched as a beat is
    // accepted; the write of the instruction leaving the execute stage on
    // that same edge is caught by the hit bits and the bypass register.
    // ------------------------------------------------------------------
    assign rd_idx[0]        = beat_in.src0_reg;
    assign rd_idx[1]        = beat_in.src1_reg;
    assign rd_idx[2]        = beat_in.src2_reg;
    assign rd_idx[OUT_PORT] = output_reg_reg;

    genvar p, l;
    generate
        for (p = 0; p < NPORT; p++)
        begin : g_port
            assign rd_addr[p] = AW'(rd_idx[p]);
            assign rd_ok[p]   = {1'b0, rd_idx[p]} < 6'(DEPTH);

            for (l = 0; l < 4; l++)
            begin : g_lane
                vsa_pkg::lane_t mem [DEPTH];
                vsa_pkg::lane_t rd_lane_reg;

                always_ff @(posedge clk)
                begin
                    if (s1_fire && wr.en[l])
                        mem[dst_addr] <= wr.data[l];
                    if (s_fire)
                        rd_lane_reg <= mem[rd_addr[p]];
                end

                assign rd_data[p][l] = rd_lane_reg;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            byp_reg <= wr.data;
            for (int q = 0; q < NPORT; q++)
            begin
                srcv_reg[q] <= rd_ok[q] ? valid_next[rd_addr[q]] : 4'h0;
                hit_reg[q]  <= (s1_fire && ins_reg.dst_reg == rd_idx[q]) ? wr.en : 4'h0;
            end
        end
    end

    always_comb
    begin
        for (int q = 0; q < NPORT; q++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (!srcv_reg[q][k])
                    src_whole[q][k] = '0;
                else if (hit_reg[q][k])
                    src_whole[q][k] = byp_reg[k];
                else
                    src_whole[q][k] = rd_data[q][k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Reported register after this instruction, and the slot count.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (clr)
                out_lanes[k] = '0;
            else if (wr.en[k] && ins_reg.dst_reg == output_reg_reg)
                out_lanes[k] = wr.data[k];
            else
                out_lanes[k] = src_whole[OUT_PORT][k];
        end
    end

    assign slot_sum  = {1'b0, slot_reg} + 17'(slots);
    assign slot_next = clr ? 16'd0 : (slot_sum[16] ? 16'hFFFF : slot_sum[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else if (s1_fire)
            slot_reg <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_reg.out_x      <= out_lanes[0];
            out_reg.out_y      <= out_lanes[1];
            out_reg.out_z      <= out_lanes[2];
            out_reg.out_w      <= out_lanes[3];
            out_reg.slot_count <= slot_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule
